### rtl/afc_pkg.sv
// Shared types, constants and a saturating arithmetic helper for the box frustum culling block.
package afc_pkg;

  localparam int PLANES_PER_FRUSTUM    = 6;
  localparam int DEFAULT_FRUSTUM_COUNT = 16;
  localparam int FSEL_W                = 4;
  localparam int PLANE_W               = 3;
  localparam int COORD_W               = 32;
  localparam int ACC_W                 = 64;
  localparam int WORD_W                = 4 * COORD_W;
  localparam int S_TDATA_W             = 200;
  localparam int M_TDATA_W             = 8;

  localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(PLANES_PER_FRUSTUM - 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TEST  = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_RESULT
  } afc_state_t;

  typedef struct packed {
    logic               accept;
    logic               clr_en;
    logic               rd_en;
    logic [PLANE_W-1:0] plane;
    logic               last;
    logic               out_load;
  } afc_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic last_done;
    logic out_free;
  } afc_status_t;

  // Signed add that clamps to the 64-bit range instead of wrapping.
  function automatic logic signed [ACC_W-1:0] sat_add64(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

endpackage

### rtl/afc_ctrl.sv
// Controller state machine sequencing the clear pass, plane writes and box tests.
module afc_ctrl
  import afc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tuser,
  output logic        s_tready,
  input  afc_status_t status,
  output afc_cmd_t    cmd
);

  afc_state_t         state, state_next;
  logic [PLANE_W-1:0] plane, plane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      plane <= '0;
    end else begin
      state <= state_next;
      plane <= plane_next;
    end
  end

  always_comb begin
    state_next = state;
    plane_next = plane;
    unique case (state)
      ST_CLEAR: begin
        if (status.clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        plane_next = '0;
        if (s_tvalid && (s_tuser == CMD_TEST)) begin
          state_next = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        plane_next = plane + PLANE_W'(1);
        if (plane == LAST_PLANE) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.last_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      ST_CLEAR: cmd.clr_en = 1'b1;
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      ST_ISSUE: begin
        cmd.rd_en = 1'b1;
        cmd.plane = plane;
        cmd.last  = (plane == LAST_PLANE);
      end
      ST_DRAIN: cmd = '0;
      ST_RESULT: cmd.out_load = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/afc_dpath.sv
// Datapath: plane memory, clear counter, dot-product pipeline and result register.
module afc_dpath
  import afc_pkg::*;
#(
  parameter int FRUSTUM_COUNT = DEFAULT_FRUSTUM_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  afc_cmd_t             cmd,
  output afc_status_t          status,
  input  logic                 s_tuser,
  input  logic [S_TDATA_W-1:0] s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata
);

  localparam int DEPTH = FRUSTUM_COUNT * PLANES_PER_FRUSTUM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (AW > 7) ? AW : 7;

  // Input fields.
  logic        [FSEL_W-1:0]  in_fsel;
  logic        [PLANE_W-1:0] in_psel;
  logic        [COORD_W-1:0] in_ax, in_ay, in_az, in_bx, in_by, in_bz;
  logic        [IW-1:0]      in_base;
  logic        [IW-1:0]      wr_idx;
  logic                      fsel_ok;

  assign in_fsel = s_tdata[3:0];
  assign in_psel = s_tdata[6:4];
  assign in_ax   = s_tdata[38:7];
  assign in_ay   = s_tdata[70:39];
  assign in_az   = s_tdata[102:71];
  assign in_bx   = s_tdata[134:103];
  assign in_by   = s_tdata[166:135];
  assign in_bz   = s_tdata[198:167];

  // Base row of a frustum is fsel * 6, built from shifts.
  assign in_base = IW'({in_fsel, 2'b00}) + IW'({in_fsel, 1'b0});
  assign wr_idx  = in_base + IW'(in_psel);
  assign fsel_ok = (32'(in_fsel) < FRUSTUM_COUNT);

  // Plane memory and clearing pass.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_word;
  logic [AW-1:0]     clr_cnt;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = wr_idx[AW-1:0];
    wr_data = {in_bx, in_az, in_ay, in_ax};
    if (cmd.clr_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (cmd.accept && (s_tuser == CMD_WRITE) && fsel_ok &&
                 (in_psel <= LAST_PLANE)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  assign status.clr_done = cmd.clr_en && (32'(clr_cnt) == DEPTH - 1);

  // Latched test item.
  logic [IW-1:0]      base;
  logic               oob;
  logic [COORD_W-1:0] min_x, min_y, min_z, max_x, max_y, max_z;
  logic [IW-1:0]      rd_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      base  <= in_base;
      min_x <= in_ax;
      min_y <= in_ay;
      min_z <= in_az;
      max_x <= in_bx;
      max_y <= in_by;
      max_z <= in_bz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oob <= 1'b0;
    end else if (cmd.accept) begin
      oob <= !fsel_ok;
    end
  end

  assign rd_idx = base + IW'(cmd.plane);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_word <= mem[rd_idx[AW-1:0]];
    end
  end

  // Pipeline: read, products, x+y, +z, +offset and sign check.
  logic [3:0] vld;
  logic [3:0] lst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      lst <= '0;
    end else begin
      vld <= {vld[2:0], cmd.rd_en};
      lst <= {lst[2:0], cmd.rd_en && cmd.last};
    end
  end

  logic signed [COORD_W-1:0] nx, ny, nz, px, py, pz;
  logic signed [ACC_W-1:0]   prod_x, prod_y, prod_z, sum_xy, sum_xyz, sum_all;
  logic signed [COORD_W-1:0] off2, off3, off4;
  logic signed [ACC_W-1:0]   prod_z3;
  logic signed [ACC_W-1:0]   off_q32;
  logic                      any_neg;
  logic                      last_done;

  assign nx = rd_word[31:0];
  assign ny = rd_word[63:32];
  assign nz = rd_word[95:64];

  // Positive vertex: max corner where the normal component is non-negative.
  assign px = nx[COORD_W-1] ? min_x : max_x;
  assign py = ny[COORD_W-1] ? min_y : max_y;
  assign pz = nz[COORD_W-1] ? min_z : max_z;

  always_ff @(posedge clk) begin
    prod_x  <= ACC_W'(nx) * ACC_W'(px);
    prod_y  <= ACC_W'(ny) * ACC_W'(py);
    prod_z  <= ACC_W'(nz) * ACC_W'(pz);
    off2    <= rd_word[127:96];
    sum_xy  <= sat_add64(prod_x, prod_y);
    prod_z3 <= prod_z;
    off3    <= off2;
    sum_xyz <= sat_add64(sum_xy, prod_z3);
    off4    <= off3;
  end

  assign off_q32 = {{(ACC_W-COORD_W-16){off4[COORD_W-1]}}, off4, 16'b0};
  assign sum_all = sat_add64(sum_xyz, off_q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      any_neg   <= 1'b0;
      last_done <= 1'b0;
    end else begin
      last_done <= vld[3] && lst[3];
      if (cmd.accept) begin
        any_neg <= 1'b0;
      end else if (vld[3]) begin
        any_neg <= any_neg | sum_all[ACC_W-1];
      end
    end
  end

  assign status.last_done = last_done;

  // Result register; a new request may be taken while it waits.
  logic visible;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      visible <= oob | !any_neg;
    end
  end

  assign status.out_free = !m_tvalid || m_tready;
  assign m_tdata         = {{(M_TDATA_W-1){1'b0}}, visible};

endmodule

### rtl/aabb_frustum_cull_top.sv
// Top level of the box frustum culling block: controller and datapath.
// A box test reads its six planes from the plane memory, one a cycle, then passes
// through five pipeline stages (read, products, two saturating adds, offset add and
// sign check) and waits for the result register to be free before loading it; no
// request is accepted until then. A plane write gives no result.
// After reset a clearing pass zeroes every row of the plane memory, during which no
// request is accepted; until planes are loaded every box is visible.
module aabb_frustum_cull_top
  import afc_pkg::*;
#(
  parameter int FRUSTUM_COUNT = DEFAULT_FRUSTUM_COUNT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // frustum_sel[3:0], plane_sel[6:4], vec_a_x[38:7], vec_a_y[70:39], vec_a_z[102:71],
  // vec_b_x[134:103], vec_b_y[166:135], vec_b_z[198:167], zero pad [199]
  input  logic [S_TDATA_W-1:0] s_tdata,
  // cmd[0]
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // box_visible[0], zero pad [7:1]
  output logic [M_TDATA_W-1:0] m_tdata
);

  afc_cmd_t    cmd;
  afc_status_t status;

  afc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  afc_dpath #(
    .FRUSTUM_COUNT (FRUSTUM_COUNT)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

### tb/tb_aabb_frustum_cull_top.sv
// Self-checking bench for the box frustum culling block: directed table, random requests.
module tb_aabb_frustum_cull_top
  import afc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRUSTUMS      = DEFAULT_FRUSTUM_COUNT;
  localparam int PLANE_SLOTS   = FRUSTUMS * PLANES_PER_FRUSTUM;
  localparam int RANDOM_ITEMS  = 1500;
  localparam int DRAIN_CYCLES  = 30;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_LIMIT  = 10;

  localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                      cmd;
    logic [FSEL_W-1:0]         frustum;
    logic [PLANE_W-1:0]        plane;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
  } cull_req_t;

  typedef enum logic [1:0] {
    ANS_PREDICT,
    ANS_VISIBLE,
    ANS_CULLED
  } answer_t;

  typedef struct {
    cull_req_t req;
    answer_t   answer;
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  logic signed [COORD_W-1:0] normal_x_mem [PLANE_SLOTS];
  logic signed [COORD_W-1:0] normal_y_mem [PLANE_SLOTS];
  logic signed [COORD_W-1:0] normal_z_mem [PLANE_SLOTS];
  logic signed [COORD_W-1:0] offset_mem   [PLANE_SLOTS];

  logic       visible_q [$];
  table_row_t directed_rows [$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  int         items_done = 0;
  int         tx_idle_pct = 0;
  int         rx_stall_pct = 0;

  aabb_frustum_cull_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Signed add held to the 64-bit range: a carry into the guard bit means overflow.
  function automatic logic signed [ACC_W-1:0] clamp_sum(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] wide;
    wide = a + b;
    if (wide[ACC_W] != wide[ACC_W-1]) begin
      return wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end
    return wide[ACC_W-1:0];
  endfunction

  function automatic logic predict_visible(input cull_req_t req);
    int                      slot;
    logic signed [ACC_W-1:0] nx, ny, nz, off, px, py, pz, acc;
    logic                    culled;
    culled = 1'b0;
    if (req.frustum >= FRUSTUMS) begin
      return 1'b1;
    end
    for (int p = 0; p < PLANES_PER_FRUSTUM; p++) begin
      slot = req.frustum * PLANES_PER_FRUSTUM + p;
      nx = normal_x_mem[slot];
      ny = normal_y_mem[slot];
      nz = normal_z_mem[slot];
      off = offset_mem[slot];
      // The positive vertex takes the max corner wherever the normal is not negative.
      if (nx < 0) px = req.ax; else px = req.bx;
      if (ny < 0) py = req.ay; else py = req.by;
      if (nz < 0) pz = req.az; else pz = req.bz;
      acc = nx * px;
      acc = clamp_sum(acc, ny * py);
      acc = clamp_sum(acc, nz * pz);
      acc = clamp_sum(acc, off <<< 16);
      if (acc < 0) culled = 1'b1;
    end
    return !culled;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      7:       return '0;
      8:       return $urandom_range(1) ? Q_MAX : Q_MIN;
      9:       return $urandom_range(1) ? Q_ONE : -Q_ONE;
      default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic table_row_t row(input logic cmd, input int frustum, input int plane,
                                     input logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz,
                                     input answer_t answer);
    table_row_t r;
    r.req = '{cmd, FSEL_W'(frustum), PLANE_W'(plane), ax, ay, az, bx, by, bz};
    r.answer = answer;
    return r;
  endfunction

  // Presents one request, waits for the handshake, then updates the predictor.
  task automatic send_request(input cull_req_t req, input answer_t answer);
    int slot;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.cmd;
    s_tdata  <= {1'b0, req.bz, req.by, req.bx, req.az, req.ay, req.ax, req.plane, req.frustum};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (req.cmd == CMD_WRITE) begin
      if (req.plane <= LAST_PLANE && req.frustum < FRUSTUMS) begin
        slot = req.frustum * PLANES_PER_FRUSTUM + req.plane;
        normal_x_mem[slot] = req.ax;
        normal_y_mem[slot] = req.ay;
        normal_z_mem[slot] = req.az;
        offset_mem[slot]   = req.bx;
        items_done++;
      end
    end else begin
      case (answer)
        ANS_VISIBLE: visible_q.push_back(1'b1);
        ANS_CULLED:  visible_q.push_back(1'b0);
        default:     visible_q.push_back(predict_visible(req));
      endcase
      items_done++;
    end
  endtask

  function automatic cull_req_t random_box(input int frustum);
    cull_req_t req;
    logic signed [COORD_W-1:0] t;
    req = '{CMD_TEST, FSEL_W'(frustum), PLANE_W'($urandom_range(7)),
            rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    // Most boxes are well formed; the rest keep whatever order they were drawn in.
    if ($urandom_range(9) < 8) begin
      if (req.ax > req.bx) begin t = req.ax; req.ax = req.bx; req.bx = t; end
      if (req.ay > req.by) begin t = req.ay; req.ay = req.by; req.by = t; end
      if (req.az > req.bz) begin t = req.az; req.az = req.bz; req.bz = t; end
    end
    return req;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (visible_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("unexpected result: box_visible %0d with nothing pending", m_tdata[0]);
          end
        end else begin
          if (visible_q[0] !== m_tdata[0]) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
              $display("box_visible mismatch: expected %0d, got %0d", visible_q[0], m_tdata[0]);
            end
          end
          void'(visible_q.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  initial begin
    cull_req_t req;
    int        frustum;
    int        phase;

    for (int i = 0; i < PLANE_SLOTS; i++) begin
      normal_x_mem[i] = '0;
      normal_y_mem[i] = '0;
      normal_z_mem[i] = '0;
      offset_mem[i]   = '0;
    end

    // Empty table, zero sums, ignored plane numbers, vertex choice and saturation.
    directed_rows.push_back(row(CMD_TEST, 0, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                                ANS_VISIBLE));
    directed_rows.push_back(row(CMD_TEST, 15, 7, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN,
                                ANS_VISIBLE));
    directed_rows.push_back(row(CMD_WRITE, 3, 0, 0, 0, 0, -1, 0, 0, ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 3, 0, 0, 0, 0, 0, 0, 0, ANS_CULLED));
    directed_rows.push_back(row(CMD_WRITE, 3, 0, 0, 0, 0, 0, Q_MAX, Q_MIN, ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 3, 5, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                                ANS_VISIBLE));
    directed_rows.push_back(row(CMD_WRITE, 2, 6, 0, 0, 0, -1, 0, 0, ANS_PREDICT));
    directed_rows.push_back(row(CMD_WRITE, 2, 7, 0, 0, 0, -1, 0, 0, ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 2, 0, 0, 0, 0, 0, 0, 0, ANS_VISIBLE));
    directed_rows.push_back(row(CMD_TEST, 3, 0, 0, 0, 0, 0, 0, 0, ANS_VISIBLE));
    directed_rows.push_back(row(CMD_WRITE, 15, 5, Q_ONE, 0, 0, 0, 0, 0, ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 15, 0, -Q_ONE, 0, 0, 0, 0, 0, ANS_VISIBLE));
    directed_rows.push_back(row(CMD_TEST, 15, 0, -Q_ONE, 0, 0, -1, 0, 0, ANS_CULLED));
    directed_rows.push_back(row(CMD_WRITE, 15, 0, -Q_ONE, -Q_ONE, -Q_ONE, Q_MAX, 0, 0,
                                ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 15, 0, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX,
                                ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 15, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
                                ANS_PREDICT));
    directed_rows.push_back(row(CMD_WRITE, 5, 2, Q_MIN, Q_MIN, Q_MIN, Q_MAX, 0, 0,
                                ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 5, 0, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 5, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, ANS_PREDICT));
    directed_rows.push_back(row(CMD_WRITE, 6, 4, Q_MAX, Q_MAX, Q_MAX, Q_MIN, 0, 0,
                                ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 6, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 6, 0, 0, 0, 0, 0, 0, 0, ANS_PREDICT));
    directed_rows.push_back(row(CMD_TEST, 6, 0, Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN,
                                ANS_PREDICT));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_request(directed_rows[i].req, directed_rows[i].answer);

    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      phase = items_done * 4 / RANDOM_ITEMS;
      case (phase)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 65; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 65; end
        default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
      endcase
      frustum = $urandom_range(FRUSTUMS - 1);
      if ($urandom_range(9) < 7) begin
        // Load a frustum, now and then skipping a plane, then aim a burst of boxes at it.
        for (int p = 0; p < PLANES_PER_FRUSTUM; p++) begin
          if ($urandom_range(9) != 0) begin
            req = '{CMD_WRITE, FSEL_W'(frustum), PLANE_W'(p), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord()};
            send_request(req, ANS_PREDICT);
          end
        end
        repeat ($urandom_range(2, 8)) send_request(random_box(frustum), ANS_PREDICT);
      end else begin
        req = random_box(frustum);
        req.cmd = 1'($urandom_range(1));
        send_request(req, ANS_PREDICT);
      end
    end
    s_tvalid <= 1'b0;

    while (visible_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
